FILE: design/ctsc_pkg.sv
// ----------------------------------------------------------------------------
// ctsc_pkg
// shared types, constants and tube code table for the clock time setter
// ----------------------------------------------------------------------------
`default_nettype none

package ctsc_pkg;

  // register reset and blink timing
  localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
  localparam int unsigned BLINK_PERIOD   = 250;
  localparam int unsigned BLINK_W        = (BLINK_PERIOD > 1) ? $clog2(BLINK_PERIOD) : 1;
  localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_PERIOD - 1);

  // digit positions while setting
  localparam logic [1:0] DIG_HOURS_TENS   = 2'd0;
  localparam logic [1:0] DIG_HOURS_UNITS  = 2'd1;
  localparam logic [1:0] DIG_MINUTES_TENS = 2'd2;
  localparam logic [1:0] DIG_MINUTES_UNITS = 2'd3;

  // step limits per digit
  localparam logic [3:0] LIMIT_HOURS_TENS   = 4'd3;
  localparam logic [3:0] LIMIT_HOURS_UNITS2 = 4'd5;
  localparam logic [3:0] LIMIT_MINUTES_TENS = 4'd6;
  localparam logic [3:0] LIMIT_DECIMAL      = 4'd10;

  // nibble value that blanks a tube
  localparam logic [3:0] DIGIT_BLANK = 4'd10;
  localparam logic [3:0] TUBE_OFF    = 4'd15;

  typedef struct packed {
    logic       ms_tick;
    logic       left_level;
    logic       right_level;
    logic [7:0] chip_hours_bcd;
    logic [7:0] chip_minutes_bcd;
  } ctsc_in_t;

  typedef struct packed {
    logic [3:0] tube_one_code;
    logic [3:0] tube_two_code;
    logic [3:0] tube_three_code;
    logic [3:0] tube_four_code;
    logic       setting_mode;
    logic       chip_write;
    logic [7:0] write_hours_bcd;
    logic [7:0] write_minutes_bcd;
  } ctsc_out_t;

  // digit to tube pin code, anything above nine is off
  function automatic logic [3:0] tube_code(input logic [3:0] digit);
    logic [3:0] code;
    case (digit)
      4'd0: code = 4'd6;
      4'd1: code = 4'd4;
      4'd2: code = 4'd5;
      4'd3: code = 4'd1;
      4'd4: code = 4'd0;
      4'd5: code = 4'd9;
      4'd6: code = 4'd8;
      4'd7: code = 4'd2;
      4'd8: code = 4'd3;
      4'd9: code = 4'd7;
      default: code = TUBE_OFF;
    endcase
    return code;
  endfunction

  // (digit + 1) mod limit, limit at least 3 so five subtract steps suffice
  function automatic logic [3:0] digit_step(input logic [3:0] digit,
                                            input logic [3:0] limit);
    logic [4:0] v;
    v = {1'b0, digit} + 5'd1;
    for (int i = 0; i < 5; i++) begin
      if (v >= {1'b0, limit}) begin
        v = v - {1'b0, limit};
      end
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/clock_time_setting_controller.sv
// ----------------------------------------------------------------------------
// clock_time_setting_controller
// button driven time setter and tube code driver for a four tube clock
// ----------------------------------------------------------------------------
// usage:
// - one item per pass: ms tick, raw left/right button levels, chip time (bcd)
// - cfg channel writes debounce_ms (reset 100), always ready, write when idle
// - each item gives exactly one result: four tube codes, setting flag and an
//   optional chip write request with the edited bcd hours and minutes
// - timing: the result shows on out_valid_o in the cycle after the item is
//   accepted; throughput is one item per cycle while results are taken, set by
//   the single result register stage
// - stall: when out_ready_i is low the result holds in the output register
//   and in_ready_o drops only while that register is full and not taken
// - reset: running mode, buttons released, debounce timers and blink phase
//   cleared, output register empty
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_setting_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [15:0]         cfg_data_i,
  // input items
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ctsc_pkg::ctsc_in_t  in_data_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ctsc_pkg::ctsc_out_t      out_data_o
);
  import ctsc_pkg::*;

  logic              accept;
  logic [15:0]       debounce_ms_q;
  logic              left_up, right_up;

  // mode and edit state
  logic              running_q, running_d;
  logic [1:0]        digit_q, digit_d;
  logic [7:0]        edit_hours_q, edit_hours_d;
  logic [7:0]        edit_minutes_q, edit_minutes_d;

  // blink phase: elapsed ms since setting started, split into period and parity
  logic [31:0]       blink_ms_q, blink_ms_d;
  logic [BLINK_W-1:0] blink_rem_q, blink_rem_d;
  logic              blink_odd_q, blink_odd_d;

  logic [3:0]        d [4];
  logic [3:0]        limit;
  logic [3:0]        stepped;
  logic              entering;
  ctsc_out_t         res;

  logic              out_valid_q;
  ctsc_out_t         out_data_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= DEBOUNCE_RESET;
    end else if (cfg_valid_i) begin
      debounce_ms_q <= cfg_data_i;
    end
  end

  ctsc_debounce u_left (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .tick_i        (in_data_i.ms_tick),
    .level_i       (in_data_i.left_level),
    .debounce_ms_i (debounce_ms_q),
    .release_o     (left_up)
  );

  ctsc_debounce u_right (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .tick_i        (in_data_i.ms_tick),
    .level_i       (in_data_i.right_level),
    .debounce_ms_i (debounce_ms_q),
    .release_o     (right_up)
  );

  always_comb begin
    running_d      = running_q;
    digit_d        = digit_q;
    edit_hours_d   = edit_hours_q;
    edit_minutes_d = edit_minutes_q;
    entering       = 1'b0;
    limit          = LIMIT_DECIMAL;
    stepped        = '0;
    res            = '0;

    // running shows the chip time, setting shows the edit copy
    if (running_q) begin
      edit_hours_d   = in_data_i.chip_hours_bcd;
      edit_minutes_d = in_data_i.chip_minutes_bcd;
    end
    d[0] = edit_hours_d[7:4];
    d[1] = edit_hours_d[3:0];
    d[2] = edit_minutes_d[7:4];
    d[3] = edit_minutes_d[3:0];

    if (running_q) begin
      // any release enters setting at the hours tens digit
      if (left_up | right_up) begin
        running_d = 1'b0;
        digit_d   = DIG_HOURS_TENS;
        entering  = 1'b1;
      end
    end else begin
      if (left_up) begin
        if (digit_q != DIG_MINUTES_UNITS) begin
          digit_d = digit_q + 2'd1;
        end else begin
          // last digit done: write the edited time
          res.chip_write        = 1'b1;
          res.write_hours_bcd   = edit_hours_q;
          res.write_minutes_bcd = edit_minutes_q;
          running_d             = 1'b1;
        end
      end else if (right_up) begin
        if (digit_q == DIG_HOURS_TENS) begin
          limit = LIMIT_HOURS_TENS;
        end else if (digit_q == DIG_HOURS_UNITS && d[0] == 4'd2) begin
          limit = LIMIT_HOURS_UNITS2;
        end else if (digit_q == DIG_MINUTES_TENS) begin
          limit = LIMIT_MINUTES_TENS;
        end
        stepped    = digit_step(d[digit_q], limit);
        d[digit_q] = stepped;
      end
      edit_hours_d   = {d[0], d[1]};
      edit_minutes_d = {d[2], d[3]};
    end

    // blink phase follows the ms tick, restarts when setting begins
    blink_ms_d  = blink_ms_q;
    blink_rem_d = blink_rem_q;
    blink_odd_d = blink_odd_q;
    if (entering) begin
      blink_ms_d  = '0;
      blink_rem_d = '0;
      blink_odd_d = 1'b0;
    end else if (in_data_i.ms_tick) begin
      blink_ms_d = blink_ms_q + 32'd1;
      if (blink_ms_q == '1) begin
        // elapsed count wrapped to zero, so the phase restarts too
        blink_rem_d = '0;
        blink_odd_d = 1'b0;
      end else if (blink_rem_q == BLINK_LAST) begin
        blink_rem_d = '0;
        blink_odd_d = ~blink_odd_q;
      end else begin
        blink_rem_d = blink_rem_q + BLINK_W'(1);
      end
    end

    // blank the digit being set in odd blink periods
    if (!running_q && blink_odd_d) begin
      d[digit_q] = DIGIT_BLANK;
    end

    res.tube_one_code   = tube_code(d[0]);
    res.tube_two_code   = tube_code(d[1]);
    res.tube_three_code = tube_code(d[2]);
    res.tube_four_code  = tube_code(d[3]);
    res.setting_mode    = ~running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q      <= 1'b1;
      digit_q        <= DIG_HOURS_TENS;
      edit_hours_q   <= '0;
      edit_minutes_q <= '0;
      blink_ms_q     <= '0;
      blink_rem_q    <= '0;
      blink_odd_q    <= 1'b0;
    end else if (accept) begin
      running_q      <= running_d;
      digit_q        <= digit_d;
      edit_hours_q   <= edit_hours_d;
      edit_minutes_q <= edit_minutes_d;
      blink_ms_q     <= blink_ms_d;
      blink_rem_q    <= blink_rem_d;
      blink_odd_q    <= blink_odd_d;
    end
  end

  // result register, holds while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: design/ctsc_debounce.sv
// ----------------------------------------------------------------------------
// ctsc_debounce
// button debouncer with release detect, timed in millisecond ticks
// ----------------------------------------------------------------------------
`default_nettype none

module ctsc_debounce (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        tick_i,
  input  wire logic        level_i,
  input  wire logic [15:0] debounce_ms_i,
  output logic             release_o
);
  import ctsc_pkg::*;

  logic        now_q, now_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] elapsed_inc;

  always_comb begin
    // ms since last accepted change, wraps like the free running count
    elapsed_inc = elapsed_q + {31'd0, tick_i};
    now_d       = now_q;
    elapsed_d   = elapsed_inc;
    if (elapsed_inc >= {16'd0, debounce_ms_i}) begin
      now_d = level_i;
      if (level_i != now_q) begin
        elapsed_d = '0;
      end
    end
  end

  assign release_o = now_q & ~now_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= 1'b0;
      elapsed_q <= '0;
    end else if (step_i) begin
      now_q     <= now_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the clock time setting controller: every accepted
// item runs through a local copy of the debounce, edit and blink logic, and
// each result is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ctsc_pkg::*;

  // pin code per digit, digit 0 in the low nibble, ten and up read as off
  localparam logic [63:0] PIN_TABLE = {4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf,
                                       4'd7, 4'd3, 4'd2, 4'd8, 4'd9,
                                       4'd0, 4'd1, 4'd5, 4'd4, 4'd6};

  // clock, reset and dut ports, the driven ones known from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  ctsc_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ctsc_out_t   out_data;

  // local copy of the controller state, starts at its reset values
  logic [15:0] dbnc_ms   = DEBOUNCE_RESET;
  logic [31:0] ms_cnt    = '0;
  logic        l_now     = 1'b0;
  logic        l_prev    = 1'b0;
  logic [31:0] l_chg     = '0;
  logic        r_now     = 1'b0;
  logic        r_prev    = 1'b0;
  logic [31:0] r_chg     = '0;
  logic        run_mode  = 1'b1;
  logic [1:0]  dig_sel   = DIG_HOURS_TENS;
  logic [31:0] set_start = '0;
  logic [7:0]  ed_h      = '0;
  logic [7:0]  ed_m      = '0;

  // displays still owed by the dut, oldest first
  ctsc_out_t display_q[$];

  // stimulus knobs and run statistics
  logic [7:0] sess_h = 8'h12;
  logic [7:0] sess_m = 8'h34;
  bit         noisy = 1'b0;
  int         dwell_budget = 0;
  int         tx_calm = 0;
  int         rx_left = 0;
  int         items_sent = 0;
  int         results_seen = 0;
  int         pred_writes = 0;
  int         pred_blanks = 0;
  int         mismatches = 0;

  clock_time_setting_controller u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // display prediction
  // ---------------------------------------------------------------------------

  function automatic logic [3:0] pin_code(input logic [3:0] dg);
    return PIN_TABLE[{dg, 2'b00} +: 4];
  endfunction

  // one button: the previous level is always kept, a new level only gets
  // through once the hold-off since the last change has run out
  function automatic void step_button(inout logic lvl_now, inout logic lvl_prev,
                                      inout logic [31:0] chg_at, input logic raw);
    lvl_prev = lvl_now;
    if ((ms_cnt - chg_at) < {16'd0, dbnc_ms}) return;
    lvl_now = raw;
    if (lvl_prev != lvl_now) chg_at = ms_cnt;
  endfunction

  // advances the local state by one item and returns the display it causes
  function automatic ctsc_out_t next_display(input ctsc_in_t it);
    ctsc_out_t   res;
    logic [3:0]  dg [4];
    logic [1:0]  cur;
    logic [31:0] elapsed;
    logic        left_up;
    logic        right_up;
    int          limit;
    res = '0;
    if (it.ms_tick) ms_cnt = ms_cnt + 32'd1;
    step_button(l_now, l_prev, l_chg, it.left_level);
    step_button(r_now, r_prev, r_chg, it.right_level);
    left_up  = !l_now && l_prev;
    right_up = !r_now && r_prev;
    cur = dig_sel;

    // running mode tracks the chip, setting mode works on the edit copy
    if (run_mode) begin
      ed_h = it.chip_hours_bcd;
      ed_m = it.chip_minutes_bcd;
    end
    dg[0] = ed_h[7:4];
    dg[1] = ed_h[3:0];
    dg[2] = ed_m[7:4];
    dg[3] = ed_m[3:0];

    if (run_mode) begin
      // any release starts setting at the hours tens, shown unblanked
      if (left_up || right_up) begin
        run_mode  = 1'b0;
        dig_sel   = DIG_HOURS_TENS;
        set_start = ms_cnt;
      end
    end else begin
      if (left_up) begin
        if (cur != DIG_MINUTES_UNITS) begin
          dig_sel = cur + 2'd1;
        end else begin
          res.chip_write        = 1'b1;
          res.write_hours_bcd   = ed_h;
          res.write_minutes_bcd = ed_m;
          run_mode = 1'b1;
          pred_writes++;
        end
      end else if (right_up) begin
        // hours units only wraps at five when the tens digit is two
        limit = LIMIT_DECIMAL;
        if (cur == DIG_HOURS_TENS) limit = LIMIT_HOURS_TENS;
        else if (cur == DIG_HOURS_UNITS && dg[0] == 4'd2) limit = LIMIT_HOURS_UNITS2;
        else if (cur == DIG_MINUTES_TENS) limit = LIMIT_MINUTES_TENS;
        dg[cur] = 4'((int'(dg[cur]) + 1) % limit);
      end
      ed_h = {dg[0], dg[1]};
      ed_m = {dg[2], dg[3]};
      // odd blink periods blank the digit under edit, finishing pass too
      elapsed = ms_cnt - set_start;
      if ((elapsed / BLINK_PERIOD) % 2 == 1) begin
        dg[cur] = DIGIT_BLANK;
        pred_blanks++;
      end
    end

    res.tube_one_code   = pin_code(dg[0]);
    res.tube_two_code   = pin_code(dg[1]);
    res.tube_three_code = pin_code(dg[2]);
    res.tube_four_code  = pin_code(dg[3]);
    res.setting_mode    = !run_mode;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (result %0d)",
                                name, got, want, results_seen));
  endtask

  // results are taken at the rising edge, so they see pre-edge dut values
  always @(posedge clk) begin
    ctsc_out_t want;
    if (out_valid && out_ready) begin
      if (display_q.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = display_q.pop_front();
        check_field("tube_one_code", 8'(out_data.tube_one_code), 8'(want.tube_one_code));
        check_field("tube_two_code", 8'(out_data.tube_two_code), 8'(want.tube_two_code));
        check_field("tube_three_code", 8'(out_data.tube_three_code),
                    8'(want.tube_three_code));
        check_field("tube_four_code", 8'(out_data.tube_four_code),
                    8'(want.tube_four_code));
        check_field("setting_mode", 8'(out_data.setting_mode), 8'(want.setting_mode));
        check_field("chip_write", 8'(out_data.chip_write), 8'(want.chip_write));
        check_field("write_hours_bcd", out_data.write_hours_bcd, want.write_hours_bcd);
        check_field("write_minutes_bcd", out_data.write_minutes_bcd,
                    want.write_minutes_bcd);
      end
      results_seen++;
    end
  end

  // result side back-pressure: short stalls mostly, now and then a long one,
  // and ready stretches of varying length in between
  always @(negedge clk) begin
    if (rx_left > 0) begin
      rx_left--;
    end else if (!out_ready) begin
      rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 6);
      out_ready <= 1'b1;
    end else begin
      rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      out_ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly legal bcd times, sometimes any byte so nibbles above nine show up
  function automatic void new_chip_time();
    logic [3:0] tens;
    if ($urandom_range(0, 3) == 0) begin
      sess_h = 8'($urandom_range(0, 255));
    end else begin
      tens = 4'($urandom_range(0, 2));
      sess_h = {tens, 4'($urandom_range(0, (tens == 4'd2) ? 3 : 9))};
    end
    if ($urandom_range(0, 3) == 0) sess_m = 8'($urandom_range(0, 255));
    else sess_m = {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
  endfunction

  function automatic ctsc_in_t make_item(input logic tk, input logic l, input logic r);
    ctsc_in_t it;
    if (noisy && $urandom_range(0, 9) == 0) new_chip_time();
    it.ms_tick          = tk;
    it.left_level       = l;
    it.right_level      = r;
    it.chip_hours_bcd   = sess_h;
    it.chip_minutes_bcd = sess_m;
    return it;
  endfunction

  // drives one item at the falling edge and holds it until the handshake;
  // valid stays high afterwards so back-to-back items need no extra edge
  task automatic send_item(input ctsc_in_t it);
    int gap;
    int pick;
    gap = 0;
    if (tx_calm > 0) begin
      tx_calm--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 6) tx_calm = $urandom_range(20, 80);
      else if (pick < 28) gap = $urandom_range(1, 3);
      else if (pick < 32) gap = $urandom_range(8, 30);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    display_q.push_back(next_display(it));
    items_sent++;
  endtask

  // holds the buttons at the given levels until enough ms ticks have gone by,
  // at least one item; in noisy mode a button bounces now and then
  task automatic hold(input logic l, input logic r, input int ticks);
    int       seen;
    logic     tk;
    ctsc_in_t it;
    seen = 0;
    do begin
      tk = ($urandom_range(0, 4) != 0);
      it = make_item(tk, l, r);
      if (noisy && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) it.left_level = !it.left_level;
        else it.right_level = !it.right_level;
      end
      send_item(it);
      seen += int'(tk);
    end while (seen < ticks);
  endtask

  // press and release, each held long enough to get past the hold-off
  task automatic click(input logic l, input logic r);
    hold(l, r, int'(dbnc_ms) + 1 + $urandom_range(0, 1));
    hold(1'b0, 1'b0, int'(dbnc_ms) + 1 + $urandom_range(0, 1));
  endtask

  // single item press then single item release, for a zero hold-off
  task automatic tap(input logic l, input logic r);
    hold(l, r, 0);
    hold(1'b0, 1'b0, 0);
  endtask

  // stops sending and waits until every owed display has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    dbnc_ms = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // enter, walk the four digits with a few steps each and write the time;
  // sometimes both buttons at once, sometimes walks away mid-edit, and once
  // in a while sits still long enough for the digit to blink
  task automatic setting_session();
    int dwell_at;
    int steps;
    new_chip_time();
    dwell_at = -1;
    if (dwell_budget > 0 && $urandom_range(0, 2) == 0) begin
      dwell_at = $urandom_range(0, 3);
      dwell_budget--;
    end
    case ($urandom_range(0, 2))
      0: click(1'b1, 1'b0);
      1: click(1'b0, 1'b1);
      default: click(1'b1, 1'b1);
    endcase
    for (int k = 0; k < 4; k++) begin
      if (k == dwell_at) hold(1'b0, 1'b0, $urandom_range(260, 420));
      steps = $urandom_range(0, 4);
      repeat (steps) click(1'b0, 1'b1);
      if ($urandom_range(0, 9) == 0) return;
      if ($urandom_range(0, 7) == 0) click(1'b1, 1'b1);
      else click(1'b1, 1'b0);
    end
  endtask

  // fully random items, levels flipping faster than the hold-off allows
  task automatic noise_burst();
    int       n;
    ctsc_in_t it;
    n = $urandom_range(5, 20);
    repeat (n) begin
      it.ms_tick          = 1'($urandom_range(0, 1));
      it.left_level       = 1'($urandom_range(0, 1));
      it.right_level      = 1'($urandom_range(0, 1));
      it.chip_hours_bcd   = 8'($urandom_range(0, 255));
      it.chip_minutes_bcd = 8'($urandom_range(0, 255));
      send_item(it);
    end
  endtask

  task automatic run_phase(input logic [15:0] dbnc, input int budget, input int dwells,
                           input bit pause);
    int start;
    bit paused;
    set_debounce(dbnc);
    dwell_budget = dwells;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < budget) begin
      if (pause && !paused && items_sent - start >= budget / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) setting_session();
      else noise_burst();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset hold-off of 100 ms swallows every press, so the tubes just follow
  // the chip, including all-zero, all-ones and nibbles that read as off
  task automatic test_chip_display();
    send_item(ctsc_in_t'{1'b1, 1'b1, 1'b0, 8'h00, 8'h00});
    send_item(ctsc_in_t'{1'b0, 1'b0, 1'b1, 8'hff, 8'hff});
    send_item(ctsc_in_t'{1'b1, 1'b1, 1'b1, 8'h23, 8'h59});
    send_item(ctsc_in_t'{1'b0, 1'b0, 1'b0, 8'ha5, 8'h9b});
    send_item(ctsc_in_t'{1'b1, 1'b0, 1'b0, 8'h19, 8'h07});
    send_item(ctsc_in_t'{1'b1, 1'b1, 1'b0, 8'hc0, 8'h3e});
  endtask

  // zero hold-off: one item per press or release; walks all four digits
  // from an out-of-range chip time, then enters with both buttons and wraps
  // the hours tens
  task automatic test_setting_walk();
    set_debounce(16'd0);
    noisy  = 1'b0;
    sess_h = 8'haf;
    sess_m = 8'hc9;
    tap(1'b0, 1'b1);  // right release enters, no step
    tap(1'b0, 1'b1);  // hours tens ten steps to two
    tap(1'b1, 1'b0);
    tap(1'b0, 1'b1);  // hours units fifteen wraps at five with tens two
    tap(1'b1, 1'b1);  // both released: only the advance counts
    tap(1'b0, 1'b1);  // minutes tens twelve wraps at six
    tap(1'b1, 1'b0);
    tap(1'b0, 1'b1);  // minutes units nine wraps to zero
    tap(1'b1, 1'b0);  // last digit done, chip write
    sess_h = 8'h23;
    sess_m = 8'h45;
    tap(1'b1, 1'b1);  // both released while running
    tap(1'b0, 1'b1);  // hours tens two wraps to zero
  endtask

  // largest hold-off: button changes right after the last edge are ignored
  task automatic test_debounce_hold_off();
    set_debounce(16'hffff);
    hold(1'b1, 1'b1, 0);
    hold(1'b0, 1'b0, 0);
    hold(1'b1, 1'b0, 0);
    hold(1'b0, 1'b1, 0);
  endtask

  // random sessions and noise over several short hold-off settings
  task automatic test_random_sessions();
    noisy = 1'b1;
    run_phase(16'd1, 100, 0, 1'b1);
    run_phase(16'd0, 80, 1, 1'b0);
    run_phase(16'd3, 100, 0, 1'b0);
    run_phase(16'd7, 60, 0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_chip_display();
    test_setting_walk();
    test_debounce_hold_off();
    test_random_sessions();

    drain();
    if (display_q.size() != 0)
      report_mismatch($sformatf("%0d displays never arrived", display_q.size()));

    $display("covered %0d items and %0d results at hold-offs 100, 0, 65535, 1, 3 and 7 ms",
             items_sent, results_seen);
    $display("%0d chip writes and %0d blanked digits were expected, %0d mismatches",
             pred_writes, pred_blanks, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout with %0d displays still owed", display_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
